// ----- sv/lwcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lwcsp_pkg
// Shared types and constants for the cache with stream prefetch.
// ----------------------------------------------------------------------------
package lwcsp_pkg;
	localparam int SETS = 64;
	localparam int WAYS = 4;
	localparam int BUFFERS = 4;
	localparam int BUFFER_DEPTH = 4;
	localparam int SET_W = $clog2(SETS);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int BUF_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
	localparam int DEP_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int IB_MAX = SET_W;
	localparam int PADDR_W = 5;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_WB = 2'd1;
	localparam logic [1:0] KIND_DEMAND = 2'd2;
	localparam logic [1:0] KIND_PREF = 2'd3;

	localparam logic [2:0] REG_OFFSET = 3'd0;
	localparam logic [2:0] REG_INDEX = 3'd1;
	localparam logic [2:0] REG_WAYS = 3'd2;
	localparam logic [2:0] REG_PREF = 3'd3;
	localparam logic [2:0] REG_BUFS = 3'd4;
	localparam logic [2:0] REG_DEPTH = 3'd5;

	typedef struct packed {
		logic req_type;
		logic [31:0] address;
	} in_item_t;

	typedef struct packed {
		logic access_hit;
		logic [1:0] req_kind;
		logic [31:0] req_block;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [3:0] index_bits;
		logic [4:0] ways_used;
		logic prefetch_enable;
		logic [4:0] buffers_used;
		logic [4:0] buffer_depth_used;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic dirty;
		logic [3:0] rank;
		logic [31:0] tag;
	} line_t;
	typedef line_t [WAYS-1:0] set_row_t;
endpackage

// ----- sv/lru_writeback_cache_stream_prefetch_top.sv -----
// ----------------------------------------------------------------------------
// lru_writeback_cache_stream_prefetch_top
// Set-associative LRU write-back cache with stream prefetch buffers.
//
// Input channel (in_valid/in_ready/in_data) takes one access beat: read or
// write and a byte address. Output channel (out_valid/out_ready/out_data)
// gives one to six request beats per access; last marks the final one.
// An access reads its set row from the tag memory (registered read), then
// resolves hit, victim and stream buffers and writes the row back, then
// issues its beats one per cycle unless the receiver stalls; the first beat
// is valid once the row read and the lookup state are through. The next
// access is taken only in the cycle after the last beat of the previous one
// is accepted.
// Only one access is in flight so no forwarding is needed.
// Reset clears valid, dirty, ranks and stream state at once (no sweep) and
// loads register defaults. A receiver stall holds the current beat.
// Configuration must be written over APB only while idle; the block
// does not enforce this itself. pready is tied high.
// ----------------------------------------------------------------------------
module lru_writeback_cache_stream_prefetch_top import lwcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	cfg_t cfg;
	logic [1:0] state_q;
	in_item_t req_q;
	set_row_t row, new_row;
	logic [SET_W-1:0] set_idx, set_q;
	logic [3:0] ob, ib;
	logic [31:0] blk, tag, bmask, wb_blk, idx_mask;
	logic [4:0] nw;
	logic found, have_inv, wb_need, sb_hit, look_en;
	logic [WAY_W-1:0] hw, vic, tw;
	logic [31:0] pop_block;
	logic [1:0] kind_q [6];
	logic [31:0] blkq_q [6];
	logic [2:0] cnt_q, pos_q;
	logic hit_q;
	logic [1:0] kind_n [6];
	logic [31:0] blk_n [6];
	logic [2:0] cnt_n;
	logic hit_n;
	logic [4:0] depth;

	assign pready = 1'b1;
	lwcsp_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .cfg);

	assign ob = cfg.offset_bits;
	assign ib = (cfg.index_bits > 4'(IB_MAX)) ? 4'(IB_MAX) : cfg.index_bits;
	assign nw = (cfg.ways_used == 0) ? 5'd1 :
		(cfg.ways_used > 5'(WAYS)) ? 5'(WAYS) : cfg.ways_used;
	assign depth = (cfg.buffer_depth_used == 0) ? 5'd1 :
		(cfg.buffer_depth_used > 5'(BUFFER_DEPTH)) ? 5'(BUFFER_DEPTH) :
		cfg.buffer_depth_used;
	assign bmask = 32'hFFFF_FFFF >> ob;
	assign idx_mask = (32'd1 << ib) - 32'd1;
	assign blk = req_q.address >> ob;
	assign tag = 32'({1'b0, req_q.address} >> (5'(ob) + 5'(ib)));
	assign set_idx = SET_W'((in_data.address >> ob) & ((32'd1 << ib) - 32'd1));

	lwcsp_tags u_tags (.clk, .arst_n, .rd_en(in_valid && in_ready), .rd_set(set_idx),
		.rd_row(row), .wr_en(look_en), .wr_set(set_q), .wr_row(new_row));

	assign in_ready = (state_q == ST_IDLE);
	assign look_en = (state_q == ST_LOOK);

	always_comb begin
		logic [3:0] best;
		found = 1'b0;
		hw = '0;
		have_inv = 1'b0;
		vic = '0;
		best = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (5'(w) < nw && row[w].valid && row[w].tag == tag) begin
				found = 1'b1;
				hw = WAY_W'(w);
			end
			if (5'(w) < nw && !row[w].valid) begin
				have_inv = 1'b1;
			end
		end
		if (have_inv) begin
			for (int w = WAYS - 1; w >= 0; w--)
				if (5'(w) < nw && !row[w].valid) vic = WAY_W'(w);
		end else begin
			for (int w = 0; w < WAYS; w++)
				if (5'(w) < nw && (w == 0 || row[w].rank > best)) begin
					best = row[w].rank;
					vic = WAY_W'(w);
				end
		end
		tw = found ? hw : vic;
		wb_need = !found && row[vic].valid && row[vic].dirty;
		wb_blk = ((row[vic].tag << ib) | (32'(set_q) & idx_mask)) & bmask;
		new_row = row;
		for (int w = 0; w < WAYS; w++)
			if (WAY_W'(w) != tw && row[w].rank < row[tw].rank)
				new_row[w].rank = row[w].rank + 4'd1;
		new_row[tw].rank = '0;
		if (found) begin
			if (req_q.req_type) new_row[tw].dirty = 1'b1;
		end else begin
			new_row[tw].valid = 1'b1;
			new_row[tw].dirty = req_q.req_type;
			new_row[tw].tag = tag;
		end
	end

	lwcsp_stream u_stream (.clk, .arst_n, .cfg,
		.stale_en(look_en && wb_need && cfg.prefetch_enable), .stale_block(wb_blk),
		.look_en(look_en && !found && cfg.prefetch_enable), .look_block(blk),
		.bmask, .sb_hit, .pop_block);

	always_comb begin
		cnt_n = '0;
		hit_n = found;
		for (int i = 0; i < 6; i++) begin
			kind_n[i] = KIND_NONE;
			blk_n[i] = '0;
		end
		if (found) begin
			cnt_n = 3'd1;
		end else begin
			if (wb_need) begin
				kind_n[0] = KIND_WB;
				blk_n[0] = wb_blk;
				cnt_n = 3'd1;
			end
			if (cfg.prefetch_enable && sb_hit) begin
				hit_n = 1'b1;
				kind_n[cnt_n] = KIND_PREF;
				blk_n[cnt_n] = pop_block;
				cnt_n = cnt_n + 3'd1;
			end else begin
				kind_n[cnt_n] = KIND_DEMAND;
				blk_n[cnt_n] = blk;
				cnt_n = cnt_n + 3'd1;
				if (cfg.prefetch_enable) begin
					for (int w = 0; w < BUFFER_DEPTH; w++)
						if (5'(w) < depth && cnt_n < 3'd6) begin
							kind_n[cnt_n] = KIND_PREF;
							blk_n[cnt_n] = (blk + 32'(w) + 32'd1) & bmask;
							cnt_n = cnt_n + 3'd1;
						end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_LOOK;
				ST_LOOK: begin
					state_q <= ST_EMIT;
					cnt_q <= cnt_n;
					pos_q <= '0;
				end
				ST_EMIT: if (out_ready) begin
					if (pos_q + 3'd1 == cnt_q) state_q <= ST_IDLE;
					pos_q <= pos_q + 3'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
			set_q <= set_idx;
		end
		if (look_en) begin
			hit_q <= hit_n;
			kind_q <= kind_n;
			blkq_q <= blk_n;
		end
	end

	assign out_valid = (state_q == ST_EMIT);
	assign out_data.access_hit = hit_q;
	assign out_data.req_kind = kind_q[pos_q];
	assign out_data.req_block = blkq_q[pos_q];
	assign out_data.last = (pos_q + 3'd1 == cnt_q);
endmodule

// ----- sv/lwcsp_regs.sv -----
// ----------------------------------------------------------------------------
// lwcsp_regs
// Configuration register file on the APB-style port.
// ----------------------------------------------------------------------------
module lwcsp_regs import lwcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t cfg
);
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{4'd4, 4'd6, 5'd4, 1'b1, 5'd4, 5'd4};
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_OFFSET: cfg_q.offset_bits <= pwdata[3:0];
				REG_INDEX: cfg_q.index_bits <= pwdata[3:0];
				REG_WAYS: cfg_q.ways_used <= pwdata[4:0];
				REG_PREF: cfg_q.prefetch_enable <= pwdata[0];
				REG_BUFS: cfg_q.buffers_used <= pwdata[4:0];
				REG_DEPTH: cfg_q.buffer_depth_used <= pwdata[4:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = '0;
		case (idx)
			REG_OFFSET: prdata[3:0] = cfg_q.offset_bits;
			REG_INDEX: prdata[3:0] = cfg_q.index_bits;
			REG_WAYS: prdata[4:0] = cfg_q.ways_used;
			REG_PREF: prdata[0] = cfg_q.prefetch_enable;
			REG_BUFS: prdata[4:0] = cfg_q.buffers_used;
			REG_DEPTH: prdata[4:0] = cfg_q.buffer_depth_used;
			default: prdata = '0;
		endcase
	end
	assign cfg = cfg_q;
endmodule

// ----- sv/lwcsp_tags.sv -----
// ----------------------------------------------------------------------------
// lwcsp_tags
// Tag store memory: one row per set, registered synchronous read.
// Rows carry valid bits per set in flops; an invalid row reads as reset.
// ----------------------------------------------------------------------------
module lwcsp_tags import lwcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [SET_W-1:0] rd_set,
	output set_row_t rd_row,
	input  logic wr_en,
	input  logic [SET_W-1:0] wr_set,
	input  set_row_t wr_row
);
	set_row_t mem [SETS];
	set_row_t rd_q;
	logic [SETS-1:0] init_q;
	logic rd_init_q;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_set] <= wr_row;
		if (rd_en) rd_q <= mem[rd_set];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			rd_init_q <= 1'b0;
		end else begin
			if (rd_en) rd_init_q <= init_q[rd_set];
			if (wr_en) init_q[wr_set] <= 1'b1;
		end
	end
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (rd_init_q) begin
				rd_row[w] = rd_q[w];
			end else begin
				rd_row[w].valid = 1'b0;
				rd_row[w].dirty = 1'b0;
				rd_row[w].rank = 4'(w);
				rd_row[w].tag = rd_q[w].tag;
			end
		end
	end
endmodule

// ----- sv/lwcsp_stream.sv -----
// ----------------------------------------------------------------------------
// lwcsp_stream
// Stream buffers: blocks, stale marks, heads, fill flags and LRU ranks.
// Flop storage, updated by the core's stale and lookup commands per access.
// ----------------------------------------------------------------------------
module lwcsp_stream import lwcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic stale_en,
	input  logic [31:0] stale_block,
	input  logic look_en,
	input  logic [31:0] look_block,
	input  logic [31:0] bmask,
	output logic sb_hit,
	output logic [31:0] pop_block
);
	logic [31:0] blk_q [BUFFERS*BUFFER_DEPTH];
	logic [BUFFERS*BUFFER_DEPTH-1:0] stale_q;
	logic [DEP_W-1:0] head_q [BUFFERS];
	logic [BUFFERS-1:0] filled_q;
	logic [3:0] rank_q [BUFFERS];
	logic [4:0] nb, depth;
	logic [DEP_W-1:0] h [BUFFERS];
	logic [DEP_W-1:0] hit_tail, hit_head;
	logic [BUF_W-1:0] hit_b;
	logic [BUF_W-1:0] refill_sel;
	logic found_st;
	logic [BUF_W-1:0] st_b;
	logic [DEP_W-1:0] st_p;

	assign nb = (cfg.buffers_used == 0) ? 5'd1 :
		(cfg.buffers_used > 5'(BUFFERS)) ? 5'(BUFFERS) : cfg.buffers_used;
	assign depth = (cfg.buffer_depth_used == 0) ? 5'd1 :
		(cfg.buffer_depth_used > 5'(BUFFER_DEPTH)) ? 5'(BUFFER_DEPTH) :
		cfg.buffer_depth_used;

	always_comb begin
		logic [3:0] best;
		logic [5:0] q;
		logic [5:0] r;
		sb_hit = 1'b0;
		hit_b = '0;
		hit_head = '0;
		hit_tail = '0;
		refill_sel = '0;
		best = '0;
		found_st = 1'b0;
		st_b = '0;
		st_p = '0;
		for (int b = 0; b < BUFFERS; b++) begin
			r = 6'(head_q[b]);
			for (int i = 0; i < BUFFER_DEPTH; i++)
				if (r >= 6'(depth)) r = r - 6'(depth);
			h[b] = DEP_W'(r);
		end
		for (int b = BUFFERS - 1; b >= 0; b--) begin
			if (5'(b) < nb && filled_q[b] && !stale_q[b*BUFFER_DEPTH + int'(h[b])]
				&& blk_q[b*BUFFER_DEPTH + int'(h[b])] == look_block) begin
				sb_hit = 1'b1;
				hit_b = BUF_W'(b);
				hit_head = h[b];
				hit_tail = (h[b] == 0) ? DEP_W'(depth - 5'd1) : DEP_W'(h[b] - 1'b1);
			end
		end
		for (int b = 0; b < BUFFERS; b++) begin
			if (5'(b) < nb && (b == 0 || rank_q[b] > best)) begin
				best = rank_q[b];
				refill_sel = BUF_W'(b);
			end
		end
		for (int b = BUFFERS - 1; b >= 0; b--) begin
			for (int k = BUFFER_DEPTH - 1; k >= 0; k--) begin
				q = 6'(h[b]) + 6'(k);
				if (q >= 6'(depth)) q = q - 6'(depth);
				if (5'(b) < nb && 5'(k) < depth && filled_q[b]
					&& blk_q[b*BUFFER_DEPTH + int'(q)] == stale_block) begin
					found_st = 1'b1;
					st_b = BUF_W'(b);
					st_p = DEP_W'(q);
				end
			end
		end
	end
	assign pop_block = (blk_q[int'(hit_b)*BUFFER_DEPTH + int'(hit_tail)] + 32'd1) & bmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= '0;
			filled_q <= '0;
			for (int b = 0; b < BUFFERS; b++) begin
				head_q[b] <= '0;
				rank_q[b] <= 4'(b);
			end
		end else begin
			if (stale_en && found_st)
				stale_q[int'(st_b)*BUFFER_DEPTH + int'(st_p)] <= 1'b1;
			if (look_en) begin
				logic [BUF_W-1:0] s;
				s = sb_hit ? hit_b : refill_sel;
				for (int b = 0; b < BUFFERS; b++)
					if (BUF_W'(b) != s && rank_q[b] < rank_q[s]) rank_q[b] <= rank_q[b] + 4'd1;
				rank_q[s] <= '0;
				if (sb_hit) begin
					stale_q[int'(hit_b)*BUFFER_DEPTH + int'(hit_head)] <= 1'b0;
					head_q[hit_b] <= (32'(hit_head) + 1 >= 32'(depth)) ? '0 :
						DEP_W'(hit_head + 1'b1);
				end else begin
					for (int w = 0; w < BUFFER_DEPTH; w++)
						if (5'(w) < depth) stale_q[int'(refill_sel)*BUFFER_DEPTH + w] <= 1'b0;
					head_q[refill_sel] <= '0;
					filled_q[refill_sel] <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (look_en) begin
			if (sb_hit) begin
				blk_q[int'(hit_b)*BUFFER_DEPTH + int'(hit_head)] <= pop_block;
			end else begin
				for (int w = 0; w < BUFFER_DEPTH; w++)
					if (5'(w) < depth)
						blk_q[int'(refill_sel)*BUFFER_DEPTH + w] <=
							(look_block + 32'(w) + 32'd1) & bmask;
			end
		end
	end
endmodule

// ----- sv/lwcsp_checker.sv -----
// ----------------------------------------------------------------------------
// lwcsp_checker
// Port-level checks on the cache top level.
// ----------------------------------------------------------------------------
module lwcsp_checker import lwcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_ready,
	input  logic out_valid,
	input  logic out_ready,
	input  out_item_t out_data,
	input  logic pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled beat changed");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken during output");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid &&
		out_data.access_hit == $past(out_data.access_hit))
		else $error("hit flag changed within access");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.req_kind == KIND_NONE |-> out_data.last &&
		out_data.access_hit) else $error("bad empty beat");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind lru_writeback_cache_stream_prefetch_top lwcsp_checker u_chk (.clk, .arst_n,
	.in_ready, .out_valid, .out_ready, .out_data, .pready);

// ----- test/lru_writeback_cache_stream_prefetch_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_writeback_cache_stream_prefetch_top_tb
// Self-checking bench for the LRU write-back cache with stream prefetch.
// A queue-fed driver offers access beats with random gaps. A monitor checks
// every request beat against a cycle-free model of tag store and stream
// buffers. Register phases are written over APB while the block is idle.
// ----------------------------------------------------------------------------
module lru_writeback_cache_stream_prefetch_top_tb;
	import lwcsp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lru_writeback_cache_stream_prefetch_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cache image
	int ob_r, ib_r, ways_r, pref_r, bufs_r, depth_r;
	logic [31:0] tag_mem [SETS*WAYS];
	bit line_ok [SETS*WAYS];
	bit line_mod [SETS*WAYS];
	int line_age [SETS*WAYS];
	logic [31:0] sb_blk [BUFFERS*BUFFER_DEPTH];
	bit sb_stale [BUFFERS*BUFFER_DEPTH];
	int sb_head [BUFFERS];
	bit sb_full [BUFFERS];
	int sb_age [BUFFERS];

	in_item_t access_q[$];
	out_item_t request_q[$];
	out_item_t req_buf[6];
	int req_n;
	int errors = 0;
	int cycles = 0;
	int beats_seen = 0;
	bit calm = 1'b0;
	bit in_acc = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_cnt = 0;
	bit long_done = 1'b0;

	function automatic int sat(int v, int hi);
		if (v < 1) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic void add_req(logic [1:0] kind, logic [31:0] blkno);
		if (req_n >= 6) return;
		req_buf[req_n].req_kind = kind;
		req_buf[req_n].req_block = blkno;
		req_n++;
	endfunction

	function automatic void touch_way(int base, int w);
		int old;
		old = line_age[base+w];
		for (int j = 0; j < WAYS; j++)
			if (j != w && line_age[base+j] < old) line_age[base+j]++;
		line_age[base+w] = 0;
	endfunction

	function automatic void touch_buf(int b);
		int old;
		old = sb_age[b];
		for (int j = 0; j < BUFFERS; j++)
			if (j != b && sb_age[j] < old) sb_age[j]++;
		sb_age[b] = 0;
	endfunction

	function automatic void stale_first(logic [31:0] blkno, int nb, int dep);
		int p;
		for (int b = 0; b < nb; b++) begin
			if (sb_full[b]) begin
				for (int k = 0; k < dep; k++) begin
					p = b*BUFFER_DEPTH + (sb_head[b] % dep + k) % dep;
					if (sb_blk[p] == blkno) begin
						sb_stale[p] = 1'b1;
						return;
					end
				end
			end
		end
	endfunction

	function automatic void predict_access(in_item_t it);
		logic [31:0] bmask, blk, set_i, tg, wb, nxt;
		int ib, nw, nb, dep, base, victim, sel, best, h, p, tp;
		bit found, have, sbh, hit;
		ib = ib_r;
		while (ib > 0 && (1 << ib) > SETS) ib--;
		nw = sat(ways_r, WAYS);
		nb = sat(bufs_r, BUFFERS);
		dep = sat(depth_r, BUFFER_DEPTH);
		bmask = 32'hFFFF_FFFF >> ob_r;
		blk = it.address >> ob_r;
		set_i = blk & ((32'd1 << ib) - 1);
		tg = it.address >> (ob_r + ib);
		base = set_i * WAYS;
		victim = 0;
		found = 0;
		hit = 0;
		req_n = 0;
		for (int w = 0; w < nw && !found; w++)
			if (line_ok[base+w] && tag_mem[base+w] == tg) begin
				if (it.req_type) line_mod[base+w] = 1'b1;
				touch_way(base, w);
				found = 1;
			end
		if (found) begin
			hit = 1;
		end else begin
			have = 0;
			for (int w = 0; w < nw && !have; w++)
				if (!line_ok[base+w]) begin
					victim = w;
					have = 1;
				end
			if (!have) begin
				best = 0;
				for (int w = 0; w < nw; w++)
					if (w == 0 || line_age[base+w] > best) begin
						best = line_age[base+w];
						victim = w;
					end
			end
			if (line_ok[base+victim] && line_mod[base+victim]) begin
				wb = ((tag_mem[base+victim] << ib) | set_i) & bmask;
				add_req(KIND_WB, wb);
				if (pref_r != 0) stale_first(wb, nb, dep);
			end
			line_ok[base+victim] = 1'b1;
			line_mod[base+victim] = it.req_type;
			tag_mem[base+victim] = tg;
			touch_way(base, victim);
			if (pref_r != 0) begin
				sbh = 0;
				for (int b = 0; b < nb && !sbh; b++) begin
					if (sb_full[b]) begin
						h = sb_head[b] % dep;
						p = b*BUFFER_DEPTH + h;
						if (!sb_stale[p] && sb_blk[p] == blk) begin
							tp = b*BUFFER_DEPTH + ((h == 0) ? dep - 1 : h - 1);
							nxt = (sb_blk[tp] + 1) & bmask;
							sb_blk[p] = nxt;
							sb_stale[p] = 1'b0;
							sb_head[b] = (h + 1) % dep;
							touch_buf(b);
							add_req(KIND_PREF, nxt);
							sbh = 1;
						end
					end
				end
				if (sbh) begin
					hit = 1;
				end else begin
					add_req(KIND_DEMAND, blk);
					sel = 0;
					best = 0;
					for (int b = 0; b < nb; b++)
						if (b == 0 || sb_age[b] > best) begin
							best = sb_age[b];
							sel = b;
						end
					for (int w = 0; w < dep; w++) begin
						nxt = (blk + w + 1) & bmask;
						sb_blk[sel*BUFFER_DEPTH + w] = nxt;
						sb_stale[sel*BUFFER_DEPTH + w] = 1'b0;
						add_req(KIND_PREF, nxt);
					end
					sb_head[sel] = 0;
					sb_full[sel] = 1'b1;
					touch_buf(sel);
				end
			end else begin
				add_req(KIND_DEMAND, blk);
			end
		end
		if (req_n == 0) add_req(KIND_NONE, 32'd0);
		for (int k = 0; k < req_n; k++) begin
			req_buf[k].access_hit = hit;
			req_buf[k].last = (k == req_n - 1);
			request_q.push_back(req_buf[k]);
		end
	endfunction

	task automatic report(string what, out_item_t got, out_item_t exp);
		$display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, exp);
		errors++;
	endtask

	// input side: accept at rising edge, advance at falling edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_acc <= in_valid && in_ready;
		if (in_valid && in_ready) predict_access(in_data);
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_acc)) begin
			if (tx_gap > 0 && !calm) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (access_q.size() > 0) begin
				in_data <= access_q.pop_front();
				in_valid <= 1'b1;
				tx_gap <= gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else if (beats_seen >= 30 && !long_done) begin
				long_done <= 1'b1;
				hold_cnt <= 120;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp;
		if (out_valid && out_ready) begin
			beats_seen <= beats_seen + 1;
			if (request_q.size() == 0) begin
				report("unexpected beat", out_data, '0);
			end else begin
				exp = request_q.pop_front();
				if (out_data.access_hit !== exp.access_hit) report("access_hit", out_data, exp);
				if (out_data.req_kind !== exp.req_kind) report("req_kind", out_data, exp);
				if (out_data.req_block !== exp.req_block) report("req_block", out_data, exp);
				if (out_data.last !== exp.last) report("last", out_data, exp);
			end
		end
	end

	task automatic apb_write(logic [2:0] regno, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({regno, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (regno)
			REG_OFFSET: ob_r = val & 15;
			REG_INDEX: ib_r = val & 15;
			REG_WAYS: ways_r = val & 31;
			REG_PREF: pref_r = val & 1;
			REG_BUFS: bufs_r = val & 31;
			default: depth_r = val & 31;
		endcase
	endtask

	task automatic drain();
		wait (access_q.size() == 0 && !in_valid && request_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_access(bit wr, logic [31:0] addr);
		in_item_t it;
		it.req_type = wr;
		it.address = addr;
		access_q.push_back(it);
	endtask

	task automatic random_accesses(int count);
		logic [31:0] blkno, stream_at;
		int r;
		stream_at = $urandom;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				stream_at = stream_at + 1;
				blkno = stream_at;
			end else if (r < 75) begin
				blkno = stream_at - $urandom_range(0, 8) + ($urandom_range(0, 3) << ib_r);
			end else if (r < 85) begin
				stream_at = $urandom;
				blkno = stream_at;
			end else begin
				add_access($urandom_range(0, 1), $urandom);
				continue;
			end
			add_access($urandom_range(0, 1),
				(blkno << ob_r) | ($urandom & ((32'd1 << ob_r) - 1)));
		end
	endtask

	initial begin
		int settings [6][6];
		settings = '{
			'{4, 6, 4, 1, 4, 31},
			'{0, 0, 1, 1, 1, 4},
			'{15, 15, 31, 0, 16, 3},
			'{8, 10, 0, 1, 0, 2},
			'{2, 3, 3, 1, 31, 1},
			'{6, 2, 16, 1, 3, 0}
		};
		ob_r = 4; ib_r = 6; ways_r = 4; pref_r = 1; bufs_r = 4; depth_r = 4;
		for (int i = 0; i < SETS*WAYS; i++) begin
			line_ok[i] = 0;
			line_mod[i] = 0;
			line_age[i] = i % WAYS;
		end
		for (int i = 0; i < BUFFERS*BUFFER_DEPTH; i++) sb_stale[i] = 0;
		for (int i = 0; i < BUFFERS; i++) begin
			sb_head[i] = 0;
			sb_full[i] = 0;
			sb_age[i] = i;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(REG_OFFSET, settings[ph][0]);
			apb_write(REG_INDEX, settings[ph][1]);
			apb_write(REG_WAYS, settings[ph][2]);
			apb_write(REG_PREF, settings[ph][3]);
			apb_write(REG_BUFS, settings[ph][4]);
			apb_write(REG_DEPTH, settings[ph][5]);
			calm = (ph == 3);
			if (ph == 0) begin
				add_access(0, 32'h0000_0000);
				add_access(0, 32'h0000_0010);
				add_access(1, 32'h0000_0010);
				add_access(1, 32'h0000_0030);
				add_access(1, 32'h0000_0430);
				add_access(1, 32'h0000_0830);
				add_access(0, 32'h0000_0C30);
				add_access(0, 32'h0000_1030);
				add_access(0, 32'h0000_0020);
				add_access(0, 32'h0000_0030);
				add_access(1, 32'hFFFF_FFFF);
				add_access(0, 32'hFFFF_FFF0);
				add_access(1, 32'h0000_0000);
				add_access(1, 32'h0000_0400);
				add_access(1, 32'h0000_0800);
				add_access(1, 32'h0000_0C00);
				add_access(0, 32'h0000_1000);
				add_access(0, 32'h0000_1400);
				add_access(0, 32'hAAAA_5555);
				add_access(1, 32'h5555_AAAA);
			end
			random_accesses(ph == 0 ? 10 : 16);
			drain();
		end
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
